@@ rtl/assert_macros.svh @@
// assertion helpers for the allocator checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define PFBA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define PFBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pfba_pkg.sv @@
package pfba_pkg;

  localparam int FRAMES_DEF    = 4096;
  localparam int WORD_BITS_DEF = 32;
  localparam int FRAME_W       = 12;
  localparam int COUNT_W       = 13;
  localparam int COUNT_RESET   = 4096;

  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_TEST  = 2'd2;

  localparam logic [1:0] STAT_DONE      = 2'd0;
  localparam logic [1:0] STAT_NO_CHANGE = 2'd1;
  localparam logic [1:0] STAT_NO_FRAME  = 2'd2;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_EVAL
  } pfba_state_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [FRAME_W-1:0] frame_number;
    logic               kernel_page;
    logic               write_access;
  } pfba_in_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               present;
    logic               writable;
    logic               user_mode;
    logic [1:0]         status;
    logic               is_used;
  } pfba_out_t;

endpackage

@@ rtl/pfba_ram.sv @@
module pfba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/physical_frame_bitmap_allocator.sv @@
// channel   ports                          beat taken when
// input     start, busy, in_data           start high and busy low
// result    out_valid, out_data            out_valid high (one cycle strobe)
// config    cfg_we, cfg_wdata              cfg_we high
//
// test, free and mapped-page allocate: the decode state reads the ram word, then the eval state
// registers the result strobe; allocate of a new frame stays in eval for each full word skipped
// from the low-water word hint, one bitmap word read per cycle from the ram
// after reset a clearing pass zeroes all FRAMES/WORD_BITS ram words and holds busy high
// results cannot be stalled; a new beat may be accepted while a result is shown
module physical_frame_bitmap_allocator #(
  parameter int FRAMES    = pfba_pkg::FRAMES_DEF,
  parameter int WORD_BITS = pfba_pkg::WORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  pfba_pkg::pfba_in_t             in_data,
  output logic                           out_valid,
  output pfba_pkg::pfba_out_t            out_data,
  input  logic                           cfg_we,
  input  logic [pfba_pkg::COUNT_W-1:0]   cfg_wdata
);

  import pfba_pkg::*;

  localparam int WORDS      = FRAMES / WORD_BITS;
  localparam int WIDX       = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SW         = $clog2(WORDS + 1);
  localparam int BW         = $clog2(WORD_BITS);
  localparam int FrameLimit = WORDS * WORD_BITS;
  localparam int DivShift   = COUNT_W + BW;
  localparam logic [COUNT_W+1:0] DivMul =
    (COUNT_W + 2)'(((64'd1 << DivShift) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));
  localparam int LimitReset = ((COUNT_RESET > FRAMES) ? FRAMES : COUNT_RESET) / WORD_BITS;

  function automatic logic [COUNT_W-1:0] div_word(input logic [COUNT_W-1:0] x);
    logic [2*COUNT_W+1:0] prod;
    prod = (2*COUNT_W + 2)'(x) * (2*COUNT_W + 2)'(DivMul);
    return COUNT_W'(prod >> DivShift);
  endfunction

  pfba_state_t          state_r, state_nxt;
  pfba_in_t             in_r, in_nxt;
  logic [COUNT_W-1:0]   q_r, q_nxt;
  logic [SW-1:0]        scan_r, scan_nxt;
  logic [WIDX-1:0]      hint_r, hint_nxt;
  logic [WIDX-1:0]      clr_r, clr_nxt;
  logic [COUNT_W-1:0]   frame_count_r;
  logic [SW-1:0]        limit_words_r;
  logic                 out_valid_r, out_valid_nxt;
  pfba_out_t            out_r, out_nxt;

  logic                 ram_we, ram_re;
  logic [WIDX-1:0]      ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, word;

  logic [COUNT_W-1:0]   count_limit;
  logic [COUNT_W-1:0]   fnum_ext;
  logic [31:0]          rem_full;
  logic [BW-1:0]        bit_idx;
  logic                 in_range, used_bit, new_alloc;
  logic [WORD_BITS-1:0] inv_word, low_zero, clr_mask;
  logic [BW-1:0]        low_idx;
  logic [31:0]          found_frame;

  pfba_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(word)
  );

  // search limit in frames, clamped to FRAMES; divided into whole words for limit_words_r
  assign count_limit = (32'(frame_count_r) > FRAMES) ? COUNT_W'(FRAMES) : frame_count_r;

  assign fnum_ext  = COUNT_W'(in_r.frame_number);
  assign rem_full  = 32'(fnum_ext) - 32'(q_r) * 32'(WORD_BITS);
  assign bit_idx   = rem_full[BW-1:0];
  assign in_range  = 32'(fnum_ext) < FrameLimit;
  assign used_bit  = in_range && word[bit_idx];
  assign new_alloc = (in_r.action == ACT_ALLOC) && (in_r.frame_number == '0);
  assign clr_mask  = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_idx;

  // lowest clear bit of the word
  assign inv_word = ~word;
  assign low_zero = inv_word & (~inv_word + {{(WORD_BITS-1){1'b0}}, 1'b1});

  always_comb begin
    low_idx = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (low_zero[b]) begin
        low_idx = low_idx | BW'(b);
      end
    end
  end

  assign found_frame = 32'(scan_r) * 32'(WORD_BITS) + 32'(low_idx);

  always_comb begin
    state_nxt     = state_r;
    in_nxt        = in_r;
    q_nxt         = q_r;
    scan_nxt      = scan_r;
    hint_nxt      = hint_r;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = q_r[WIDX-1:0];
    ram_wdata     = word;
    ram_re        = 1'b0;
    ram_raddr     = q_r[WIDX-1:0];

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (32'(clr_r) == WORDS - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          in_nxt    = in_data;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        q_nxt    = div_word(fnum_ext);
        scan_nxt = SW'(hint_r);
        ram_re   = 1'b1;
        ram_raddr = new_alloc ? hint_r : q_nxt[WIDX-1:0];
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        out_nxt       = '0;
        out_nxt.frame = in_r.frame_number;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        case (in_r.action)
          ACT_ALLOC: begin
            if (!new_alloc) begin
              out_nxt.status  = STAT_NO_CHANGE;
              out_nxt.is_used = used_bit;
            end else if (32'(scan_r) >= 32'(limit_words_r)) begin
              out_nxt.status = STAT_NO_FRAME;
              out_nxt.frame  = '0;
            end else if (&word) begin
              // full word, fetch the next one
              out_valid_nxt = 1'b0;
              state_nxt     = S_EVAL;
              scan_nxt      = scan_r + 1'b1;
              ram_re        = 1'b1;
              ram_raddr     = scan_nxt[WIDX-1:0];
            end else begin
              ram_we            = 1'b1;
              ram_waddr         = scan_r[WIDX-1:0];
              ram_wdata         = word | low_zero;
              hint_nxt          = scan_r[WIDX-1:0];
              out_nxt.frame     = found_frame[FRAME_W-1:0];
              out_nxt.present   = 1'b1;
              out_nxt.writable  = in_r.write_access;
              out_nxt.user_mode = ~in_r.kernel_page;
              out_nxt.is_used   = 1'b1;
            end
          end
          ACT_FREE: begin
            if (in_r.frame_number == '0) begin
              out_nxt.status  = STAT_NO_CHANGE;
              out_nxt.is_used = used_bit;
            end else begin
              out_nxt.frame = '0;
              if (in_range) begin
                ram_we    = 1'b1;
                ram_wdata = word & ~clr_mask;
                if (32'(q_r) < 32'(hint_r)) begin
                  hint_nxt = q_r[WIDX-1:0];
                end
              end
            end
          end
          ACT_TEST: begin
            out_nxt.is_used = used_bit;
          end
          default: begin
            out_nxt.status  = STAT_NO_CHANGE;
            out_nxt.is_used = used_bit;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      hint_r        <= '0;
      clr_r         <= '0;
      frame_count_r <= COUNT_W'(COUNT_RESET);
      limit_words_r <= SW'(LimitReset);
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      hint_r        <= hint_nxt;
      clr_r         <= clr_nxt;
      limit_words_r <= SW'(div_word(count_limit));
      out_valid_r   <= out_valid_nxt;
      if (cfg_we) begin
        frame_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    in_r   <= in_nxt;
    q_r    <= q_nxt;
    scan_r <= scan_nxt;
    out_r  <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/pfba_checker.sv @@
`include "assert_macros.svh"

module pfba_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input pfba_pkg::pfba_out_t          out_data
);

  import pfba_pkg::*;

  logic accept;
  logic granted;
  logic grant_ok;
  logic no_frame;
  logic no_frame_ok;

  assign accept      = start && !busy;
  assign granted     = out_valid && out_data.present;
  assign grant_ok    = (out_data.status == STAT_DONE) && out_data.is_used;
  assign no_frame    = out_valid && (out_data.status == STAT_NO_FRAME);
  assign no_frame_ok = (out_data.frame == '0) && !out_data.present && !out_data.is_used;

  `PFBA_ASSERT_NEXT(a_busy_after_accept, accept, busy, "busy low after an accepted beat")
  `PFBA_ASSERT_NEXT(a_no_result_after_accept, accept, !out_valid, "result right after accept")
  `PFBA_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe held two cycles")
  `PFBA_ASSERT_IMPL(a_present_done, granted, grant_ok, "present frame not marked used")
  `PFBA_ASSERT_IMPL(a_no_frame_clean, no_frame, no_frame_ok, "full bitmap result not cleared")

endmodule

bind physical_frame_bitmap_allocator pfba_checker u_pfba_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid),
  .out_data (out_data)
);
